// ===== rtl/crcfd_pkg.sv =====
// Shared constants, types and the byte-wise CRC-32 update for the frame decoder.
`default_nettype none

package crcfd_pkg;

   // Header layout: nonce bytes, then the captured little-endian CRC.
   localparam int unsigned NonceBytes  = 16;
   localparam int unsigned CrcBytes    = 4;
   localparam int unsigned HeaderBytes = NonceBytes + CrcBytes;

   // CRC-32 (IEEE), reflected form.
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Header position counter width; it saturates at the header length.
   localparam int unsigned PosWidth = 5;
   localparam logic [PosWidth-1:0] POS_NONCE_END  = PosWidth'(NonceBytes);
   localparam logic [PosWidth-1:0] POS_HEADER_END = PosWidth'(HeaderBytes);

   // End-of-packet status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;

   // One result as produced by the frame tracker for the current byte.
   typedef struct packed {
      logic       emit;
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       end_of_packet;
      logic [1:0] status;
   } result_type;

   // Fold one byte into a reflected CRC register, one bit per step.
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfd_frame_tracker.sv =====
// Per-packet header tracking, CRC accumulation and result formation.
`default_nettype none

module crcfd_frame_tracker
   import crcfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,         // a byte is transferred this cycle
   input  wire logic       header_enabled,
   input  wire logic [7:0] data_byte,
   input  wire logic       last,
   output result_type      result           // result for the byte now presented
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [31:0]         exp_crc_ff, exp_crc_in;
   logic [31:0]         run_crc_ff, run_crc_in;

   logic        in_nonce;
   logic        in_crc_field;
   logic        is_payload;
   logic [31:0] crc_fed;
   logic [1:0]  end_status;

   assign in_nonce     = pos_ff < POS_NONCE_END;
   assign in_crc_field = !in_nonce && (pos_ff < POS_HEADER_END);
   assign is_payload   = !in_nonce && !in_crc_field;
   assign crc_fed      = crc_feed(run_crc_ff, data_byte);

   // Header state after this byte, before any end-of-packet restart.
   always_comb begin
      pos_in     = pos_ff;
      exp_crc_in = exp_crc_ff;
      run_crc_in = run_crc_ff;
      if (header_enabled) begin
         if (!is_payload) begin
            pos_in = pos_ff + PosWidth'(1);
         end
         if (in_crc_field) begin
            exp_crc_in[{pos_ff[1:0], 3'b000} +: 8] = data_byte;
         end
         if (is_payload) begin
            run_crc_in = crc_fed;
         end
      end
   end

   // Status at packet end, judged on the state that includes this byte.
   always_comb begin
      if (pos_in < POS_HEADER_END) begin
         end_status = STATUS_SHORT;
      end else if ((run_crc_in ^ CRC_ALL_ONES) != exp_crc_in) begin
         end_status = STATUS_MISMATCH;
      end else begin
         end_status = STATUS_OK;
      end
   end

   // Result for the current byte.
   always_comb begin
      if (!header_enabled) begin
         result.emit          = 1'b1;
         result.payload_byte  = data_byte;
         result.byte_valid    = 1'b1;
         result.end_of_packet = last;
         result.status        = STATUS_OK;
      end else begin
         result.emit          = is_payload || last;
         result.payload_byte  = is_payload ? data_byte : 8'd0;
         result.byte_valid    = is_payload;
         result.end_of_packet = last;
         result.status        = last ? end_status : STATUS_OK;
      end
   end

   // Packet state registers; any last byte restarts the packet.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         exp_crc_ff <= '0;
         run_crc_ff <= CRC_ALL_ONES;
      end else if (step_en) begin
         if (last) begin
            pos_ff     <= '0;
            exp_crc_ff <= '0;
            run_crc_ff <= CRC_ALL_ONES;
         end else begin
            pos_ff     <= pos_in;
            exp_crc_ff <= exp_crc_in;
            run_crc_ff <= run_crc_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/crc32_checked_frame_decoder_core.sv =====
// Top level of the CRC-32 checked frame decoder: handshakes and result register.
//
//   Channel  Direction  Handshake               Contents
//   req_     in         req_tvalid/req_tready   one packet byte, tlast on final byte
//   rsp_     out        rsp_tvalid/rsp_tready   payload byte, byte flag, status, tlast
//   csr_     in         csr_valid/csr_ready     header_enabled mode bit
//
// One byte is accepted per cycle, except that a stalled result holds the input back
// only while the result register stays full. A byte's result is registered and
// shows in the next cycle. The byte-wise CRC update and the compare sit between the
// packet state and the result register. Header bytes that are not the last byte give
// no result. Reset is synchronous and sets header mode and a fresh packet.
`default_nettype none

module crc32_checked_frame_decoder_core
   import crcfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // last

   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] payload_byte
   output logic [2:0]      rsp_tuser,   // [0] byte_valid, [2:1] status
   output logic            rsp_tlast,   // end_of_packet

   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_wdata    // header_enabled
);

   logic       header_enabled_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic [2:0] rsp_user_ff;
   logic       rsp_last_ff;

   logic       req_xfer;
   result_type result;

   // Mode register; writes are taken at any time.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_enabled_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         header_enabled_ff <= csr_wdata;
      end
   end

   // Input is taken whenever the result register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   crcfd_frame_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .step_en        (req_xfer),
      .header_enabled (header_enabled_ff),
      .data_byte      (req_tdata),
      .last           (req_tlast),
      .result         (result)
   );

   // Result register occupancy.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = result.emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is loaded on every transfer that produces a result.
   always_ff @(posedge clock) begin
      if (req_xfer && result.emit) begin
         rsp_data_ff <= result.payload_byte;
         rsp_user_ff <= {result.status, result.byte_valid};
         rsp_last_ff <= result.end_of_packet;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
